FILE: rtl/bounded_doubly_linked_list_core_assert.svh
// Assertion macros for the list core, clocked on clk with the synchronous reset.
`ifndef BOUNDED_DOUBLY_LINKED_LIST_CORE_ASSERT_SVH
`define BOUNDED_DOUBLY_LINKED_LIST_CORE_ASSERT_SVH

// Same-cycle implication.
`define BDL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BDL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bdl_pkg.sv
package bdl_pkg;

  typedef enum logic [3:0] {
    REQ_PUSH_BACK  = 4'd0,
    REQ_PUSH_FRONT = 4'd1,
    REQ_POP_BACK   = 4'd2,
    REQ_POP_FRONT  = 4'd3,
    REQ_BACK       = 4'd4,
    REQ_FRONT      = 4'd5,
    REQ_AT         = 4'd6,
    REQ_INSERT     = 4'd7,
    REQ_REMOVE     = 4'd8,
    REQ_CLEAR      = 4'd9,
    REQ_SIZE       = 4'd10
  } req_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ALLOC,
    S_PLACE,
    S_WALK,
    S_LINK,
    S_LINK2,
    S_RDN,
    S_UNLINK1,
    S_UNLINK2,
    S_FINISH
  } state_t;

endpackage

FILE: rtl/bounded_doubly_linked_list_core.sv
// Bounded doubly linked list of signed 32-bit values, up to DEPTH nodes.
// Input channel (in_valid / in_stall): one request per item, with
// in_req_type, in_index and in_value. A request is taken when in_valid is
// high and in_stall low; in_stall stays high while a request is in work.
// Result channel (out_valid / out_stall): one result per request with
// out_data_out, out_status and out_item_count, held in an output register.
// Size, clear, unused codes and errors go from decode straight to the
// result; back and front first read the node; pops also unlink it and
// hand it to the free list; pushes take a node (from the free list first
// when one is there), then write it and link its neighbours. at, insert
// and remove walk one link a cycle from the head to an inner index
// (remove of the last node starts at the tail); the walk issues one read
// of the next-link memory per cycle. The next request is taken in the
// cycle after out_valid rises at the earliest.
// Node value, next and prev links live in three synchronous memories with a
// registered read; all accesses of a request are ordered in separate states,
// so no read whose data is used meets a write to the same entry.
// Reset (rst_n low, synchronous) empties the list and the free list; node
// memory is not cleared, as only linked nodes are ever read. When the
// receiver stalls, the result waits in the output register and holds.
`include "bounded_doubly_linked_list_core_assert.svh"

module bounded_doubly_linked_list_core #(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_req_type,
  input  logic [6:0]         in_index,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_data_out,
  output logic [1:0]         out_status,
  output logic [6:0]         out_item_count
);

  // Pointers and counts share one width: they must hold DEPTH (null / full).
  localparam int PW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int XW = (PW > 7) ? PW : 7;
  localparam logic [PW-1:0] NIL = PW'(DEPTH);

  // Node memories
  logic signed [31:0] val_mem [DEPTH];
  logic [PW-1:0]      nxt_mem [DEPTH];
  logic [PW-1:0]      prv_mem [DEPTH];

  logic signed [31:0] rd_val;
  logic [PW-1:0]      rd_nxt, rd_prv;
  logic [AW-1:0]      rd_addr;

  logic               v_we, n_we, p_we;
  logic [AW-1:0]      v_wa, n_wa, p_wa;
  logic signed [31:0] v_wd;
  logic [PW-1:0]      n_wd, p_wd;

  bdl_pkg::state_t state_r, state_nxt;

  logic [PW-1:0] head_r, head_nxt, tail_r, tail_nxt, free_r, free_nxt;
  logic [PW-1:0] fresh_r, fresh_nxt, count_r, count_nxt;
  logic [PW-1:0] node_r, node_nxt, cur_r, cur_nxt;
  logic [PW-1:0] before_r, before_nxt, after_r, after_nxt;
  logic [PW-1:0] steps_r, steps_nxt;
  logic [3:0]    req_r, req_nxt;
  logic [6:0]    idx_r, idx_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic signed [31:0] res_data_r, res_data_nxt;
  logic [1:0]    res_status_r, res_status_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic signed [31:0] out_data_r, out_data_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [6:0]    out_count_r, out_count_nxt;

  logic [XW-1:0] idx_x, cnt_x;
  logic          is_add;

  assign idx_x  = XW'(idx_r);
  assign cnt_x  = XW'(count_r);
  assign is_add = (req_r == bdl_pkg::REQ_PUSH_BACK) || (req_r == bdl_pkg::REQ_PUSH_FRONT) ||
                  (req_r == bdl_pkg::REQ_INSERT);

  // Memory ports: one write each, one shared read address, registered data.
  always_ff @(posedge clk) begin
    if (v_we) val_mem[v_wa] <= v_wd;
    if (n_we) nxt_mem[n_wa] <= n_wd;
    if (p_we) prv_mem[p_wa] <= p_wd;
    rd_val <= val_mem[rd_addr];
    rd_nxt <= nxt_mem[rd_addr];
    rd_prv <= prv_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bdl_pkg::S_IDLE;
      head_r      <= NIL;
      tail_r      <= NIL;
      free_r      <= NIL;
      fresh_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      free_r      <= free_nxt;
      fresh_r     <= fresh_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers: no reset needed
  always_ff @(posedge clk) begin
    node_r       <= node_nxt;
    cur_r        <= cur_nxt;
    before_r     <= before_nxt;
    after_r      <= after_nxt;
    steps_r      <= steps_nxt;
    req_r        <= req_nxt;
    idx_r        <= idx_nxt;
    val_r        <= val_nxt;
    res_data_r   <= res_data_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    free_nxt       = free_r;
    fresh_nxt      = fresh_r;
    count_nxt      = count_r;
    node_nxt       = node_r;
    cur_nxt        = cur_r;
    before_nxt     = before_r;
    after_nxt      = after_r;
    steps_nxt      = steps_r;
    req_nxt        = req_r;
    idx_nxt        = idx_r;
    val_nxt        = val_r;
    res_data_nxt   = res_data_r;
    res_status_nxt = res_status_r;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_valid_nxt  = out_valid_r && out_stall;
    rd_addr        = cur_r[AW-1:0];
    v_we = 1'b0; v_wa = node_r[AW-1:0]; v_wd = val_r;
    n_we = 1'b0; n_wa = node_r[AW-1:0]; n_wd = after_r;
    p_we = 1'b0; p_wa = node_r[AW-1:0]; p_wd = before_r;
    in_stall       = (state_r != bdl_pkg::S_IDLE);

    unique case (state_r)
      bdl_pkg::S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_req_type;
          idx_nxt   = in_index;
          val_nxt   = in_value;
          state_nxt = bdl_pkg::S_DECODE;
        end
      end

      bdl_pkg::S_DECODE: begin
        res_data_nxt   = '0;
        res_status_nxt = bdl_pkg::ST_OK;
        state_nxt      = bdl_pkg::S_FINISH;
        if (is_add && !((req_r == bdl_pkg::REQ_INSERT) && (idx_x > cnt_x))) begin
          // Position: back, front or the given index
          if (req_r == bdl_pkg::REQ_PUSH_BACK) steps_nxt = count_r;
          else if (req_r == bdl_pkg::REQ_PUSH_FRONT) steps_nxt = '0;
          else steps_nxt = PW'(idx_x);
          // Take a node: free list first, then never-used nodes
          if (free_r != NIL) begin
            rd_addr   = free_r[AW-1:0];
            state_nxt = bdl_pkg::S_ALLOC;
          end else if (fresh_r != NIL) begin
            node_nxt  = fresh_r;
            fresh_nxt = fresh_r + PW'(1);
            state_nxt = bdl_pkg::S_PLACE;
          end else begin
            res_status_nxt = bdl_pkg::ST_FULL;
          end
        end else begin
          unique case (req_r) inside
            bdl_pkg::REQ_INSERT: res_status_nxt = bdl_pkg::ST_EMPTY;
            bdl_pkg::REQ_POP_BACK, bdl_pkg::REQ_BACK: begin
              if (count_r == '0) res_status_nxt = bdl_pkg::ST_EMPTY;
              else begin
                cur_nxt   = tail_r;
                rd_addr   = tail_r[AW-1:0];
                state_nxt = bdl_pkg::S_RDN;
              end
            end
            bdl_pkg::REQ_POP_FRONT, bdl_pkg::REQ_FRONT: begin
              if (count_r == '0) res_status_nxt = bdl_pkg::ST_EMPTY;
              else begin
                cur_nxt   = head_r;
                rd_addr   = head_r[AW-1:0];
                state_nxt = bdl_pkg::S_RDN;
              end
            end
            bdl_pkg::REQ_AT, bdl_pkg::REQ_REMOVE: begin
              if (idx_x >= cnt_x) res_status_nxt = bdl_pkg::ST_EMPTY;
              else if ((req_r == bdl_pkg::REQ_REMOVE) && (idx_x == cnt_x - XW'(1))) begin
                cur_nxt   = tail_r;
                rd_addr   = tail_r[AW-1:0];
                state_nxt = bdl_pkg::S_RDN;
              end else begin
                cur_nxt   = head_r;
                rd_addr   = head_r[AW-1:0];
                steps_nxt = PW'(idx_x);
                state_nxt = (idx_r == 7'd0) ? bdl_pkg::S_RDN : bdl_pkg::S_WALK;
              end
            end
            bdl_pkg::REQ_CLEAR: begin
              head_nxt  = NIL;
              tail_nxt  = NIL;
              free_nxt  = NIL;
              fresh_nxt = '0;
              count_nxt = '0;
            end
            bdl_pkg::REQ_SIZE: res_data_nxt = 32'(count_r);
            default: ;
          endcase
        end
      end

      bdl_pkg::S_ALLOC: begin
        node_nxt  = free_r;
        free_nxt  = rd_nxt;
        state_nxt = bdl_pkg::S_PLACE;
      end

      bdl_pkg::S_PLACE: begin
        state_nxt = bdl_pkg::S_LINK;
        if (count_r == '0) begin
          before_nxt = NIL;
          after_nxt  = NIL;
        end else if (steps_r == '0) begin
          before_nxt = NIL;
          after_nxt  = head_r;
        end else if (steps_r >= count_r) begin
          before_nxt = tail_r;
          after_nxt  = NIL;
        end else begin
          cur_nxt   = head_r;
          rd_addr   = head_r[AW-1:0];
          state_nxt = bdl_pkg::S_WALK;
        end
      end

      bdl_pkg::S_WALK: begin
        // Advance one link a cycle; the read of the new node is already out
        cur_nxt   = rd_nxt;
        steps_nxt = steps_r - PW'(1);
        rd_addr   = rd_nxt[AW-1:0];
        if (steps_r == PW'(1)) begin
          if (is_add) begin
            before_nxt = cur_r;
            after_nxt  = rd_nxt;
            state_nxt  = bdl_pkg::S_LINK;
          end else begin
            state_nxt = bdl_pkg::S_RDN;
          end
        end
      end

      bdl_pkg::S_LINK: begin
        v_we = 1'b1;
        n_we = 1'b1;
        p_we = 1'b1;
        state_nxt = bdl_pkg::S_LINK2;
      end

      bdl_pkg::S_LINK2: begin
        if (before_r != NIL) begin
          n_we = 1'b1;
          n_wa = before_r[AW-1:0];
          n_wd = node_r;
        end else head_nxt = node_r;
        if (after_r != NIL) begin
          p_we = 1'b1;
          p_wa = after_r[AW-1:0];
          p_wd = node_r;
        end else tail_nxt = node_r;
        count_nxt    = count_r + PW'(1);
        res_data_nxt = '0;
        state_nxt    = bdl_pkg::S_FINISH;
      end

      bdl_pkg::S_RDN: begin
        res_data_nxt = rd_val;
        before_nxt   = rd_prv;
        after_nxt    = rd_nxt;
        if (req_r inside {bdl_pkg::REQ_BACK, bdl_pkg::REQ_FRONT, bdl_pkg::REQ_AT})
          state_nxt = bdl_pkg::S_FINISH;
        else
          state_nxt = bdl_pkg::S_UNLINK1;
      end

      bdl_pkg::S_UNLINK1: begin
        if (before_r != NIL) begin
          n_we = 1'b1;
          n_wa = before_r[AW-1:0];
          n_wd = after_r;
        end else head_nxt = after_r;
        if (after_r != NIL) begin
          p_we = 1'b1;
          p_wa = after_r[AW-1:0];
          p_wd = before_r;
        end else tail_nxt = before_r;
        state_nxt = bdl_pkg::S_UNLINK2;
      end

      bdl_pkg::S_UNLINK2: begin
        // Hand the node back to the free list
        n_we      = 1'b1;
        n_wa      = cur_r[AW-1:0];
        n_wd      = free_r;
        free_nxt  = cur_r;
        count_nxt = count_r - PW'(1);
        state_nxt = bdl_pkg::S_FINISH;
      end

      bdl_pkg::S_FINISH: begin
        // Hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = res_data_r;
          out_status_nxt = res_status_r;
          out_count_nxt  = 7'(count_r);
          state_nxt      = bdl_pkg::S_IDLE;
        end
      end

      default: state_nxt = bdl_pkg::S_IDLE;
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_data_out   = out_data_r;
  assign out_status     = out_status_r;
  assign out_item_count = out_count_r;

  `BDL_ASSERT_NOW(a_count_bound, 1'b1, (count_r <= NIL) && (fresh_r <= NIL), "count overflow")
  `BDL_ASSERT_NOW(a_head_empty, state_r == bdl_pkg::S_IDLE,
                  (count_r == '0) == (head_r == NIL) && (count_r == '0) == (tail_r == NIL),
                  "head or tail disagrees with count")
  `BDL_ASSERT_NOW(a_walk_steps, state_r == bdl_pkg::S_WALK, steps_r != '0, "walk without steps")
  `BDL_ASSERT_NEXT(a_accept_decode, in_valid && !in_stall, state_r == bdl_pkg::S_DECODE,
                   "accepted request not decoded")

endmodule

FILE: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [3:0] in_req_type = '0;
  logic [6:0] in_index = '0;
  logic signed [31:0] in_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_data_out;
  logic [1:0] out_status;
  logic [6:0] out_item_count;

  typedef struct packed {
    logic signed [31:0] data;
    logic [1:0] status;
    logic [6:0] count;
  } list_result_t;

  list_result_t pending_results[$];
  int mismatch_count = 0;

  // Shadow list: simple queue of values, head at index 0. The node memory and
  // free list of the block are invisible at its ports, so only the order of
  // values matters.
  logic signed [31:0] shadow_list[$];

  bounded_doubly_linked_list_core #(.DEPTH(DEPTH)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type), .in_index(in_index), .in_value(in_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_data_out(out_data_out), .out_status(out_status),
    .out_item_count(out_item_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    // Mostly back to back, sometimes short, rarely long.
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Work out the result of one request and advance the shadow list.
  function automatic list_result_t predict_list_op(logic [3:0] req, logic [6:0] idx,
                                                   logic signed [31:0] val);
    list_result_t r;
    int cnt;
    cnt = shadow_list.size();
    r.data = '0;
    r.status = bdl_pkg::ST_OK;
    case (req)
      bdl_pkg::REQ_PUSH_BACK: begin
        if (cnt >= DEPTH) r.status = bdl_pkg::ST_FULL;
        else shadow_list.insert(cnt, val);
      end
      bdl_pkg::REQ_PUSH_FRONT: begin
        if (cnt >= DEPTH) r.status = bdl_pkg::ST_FULL;
        else shadow_list.insert(0, val);
      end
      bdl_pkg::REQ_POP_BACK: begin
        if (cnt == 0) r.status = bdl_pkg::ST_EMPTY;
        else begin
          r.data = shadow_list[cnt-1];
          shadow_list.delete(cnt-1);
        end
      end
      bdl_pkg::REQ_POP_FRONT: begin
        if (cnt == 0) r.status = bdl_pkg::ST_EMPTY;
        else begin
          r.data = shadow_list[0];
          shadow_list.delete(0);
        end
      end
      bdl_pkg::REQ_BACK: begin
        if (cnt == 0) r.status = bdl_pkg::ST_EMPTY;
        else r.data = shadow_list[cnt-1];
      end
      bdl_pkg::REQ_FRONT: begin
        if (cnt == 0) r.status = bdl_pkg::ST_EMPTY;
        else r.data = shadow_list[0];
      end
      bdl_pkg::REQ_AT: begin
        if (idx >= cnt) r.status = bdl_pkg::ST_EMPTY;
        else r.data = shadow_list[idx];
      end
      bdl_pkg::REQ_INSERT: begin
        // index is checked before space
        if (idx > cnt) r.status = bdl_pkg::ST_EMPTY;
        else if (cnt >= DEPTH) r.status = bdl_pkg::ST_FULL;
        else shadow_list.insert(idx, val);
      end
      bdl_pkg::REQ_REMOVE: begin
        if (idx >= cnt) r.status = bdl_pkg::ST_EMPTY;
        else begin
          r.data = shadow_list[idx];
          shadow_list.delete(idx);
        end
      end
      bdl_pkg::REQ_CLEAR: shadow_list.delete();
      bdl_pkg::REQ_SIZE: r.data = cnt;
      default: ;
    endcase
    r.count = 7'(shadow_list.size());
    return r;
  endfunction

  // Send one request: wait for the handshake, then, if a gap is picked, drop valid for the gap.
  task automatic send_request(logic [3:0] req, logic [6:0] idx, logic signed [31:0] val);
    int gap;
    pending_results.insert(pending_results.size(), predict_list_op(req, idx, val));
    in_valid <= 1'b1;
    in_req_type <= req;
    in_index <= idx;
    in_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic finish_stream();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Hold the sender until every pending result has returned.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Receiver stall pattern, stretches with and without stalls.
  initial begin
    int quiet;
    @(posedge rst_n);
    forever begin
      quiet = $urandom_range(0, 3);
      if (quiet == 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat (pick_gap() + 1) @(posedge clk);
      end
    end
  end

  // Compare each accepted result with the oldest pending one.
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result data=%0d status=%0d count=%0d",
                   out_data_out, out_status, out_item_count);
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (out_data_out !== want.data || out_status !== want.status ||
            out_item_count !== want.count) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result mismatch: expected data=%0d status=%0d count=%0d,",
                     want.data, want.status, want.count,
                     " got data=%0d status=%0d count=%0d",
                     out_data_out, out_status, out_item_count);
        end
      end
    end
  end

  function automatic logic signed [31:0] random_value();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_list();
    send_request(bdl_pkg::REQ_POP_BACK, 0, 0);
    send_request(bdl_pkg::REQ_POP_FRONT, 0, 0);
    send_request(bdl_pkg::REQ_BACK, 0, 0);
    send_request(bdl_pkg::REQ_FRONT, 0, 0);
    send_request(bdl_pkg::REQ_AT, 0, 0);
    send_request(bdl_pkg::REQ_REMOVE, 0, 0);
    send_request(bdl_pkg::REQ_INSERT, 1, 5);
    send_request(bdl_pkg::REQ_SIZE, 0, 0);
  endtask

  task automatic test_basic_ops();
    send_request(bdl_pkg::REQ_PUSH_BACK, 0, 32'sh7fffffff);
    send_request(bdl_pkg::REQ_PUSH_FRONT, 0, 32'sh80000000);
    send_request(bdl_pkg::REQ_INSERT, 1, -1);
    send_request(bdl_pkg::REQ_INSERT, 3, 7);
    send_request(bdl_pkg::REQ_AT, 2, 0);
    send_request(bdl_pkg::REQ_AT, 4, 0);
    send_request(bdl_pkg::REQ_BACK, 0, 0);
    send_request(bdl_pkg::REQ_FRONT, 0, 0);
    send_request(bdl_pkg::REQ_REMOVE, 1, 0);
    send_request(bdl_pkg::REQ_REMOVE, 7'd127, 0);
    send_request(bdl_pkg::REQ_POP_BACK, 0, 0);
    send_request(bdl_pkg::REQ_POP_FRONT, 0, 0);
    send_request(4'd11, 0, 0);
    send_request(4'd15, 7'd127, -1);
    send_request(bdl_pkg::REQ_CLEAR, 0, 0);
    drain_results();
  endtask

  // Fill to DEPTH, overflow, walk to the far end, then clear.
  task automatic test_full_list();
    for (int i = 0; i < DEPTH; i++) send_request(bdl_pkg::REQ_PUSH_BACK, 0, $urandom);
    send_request(bdl_pkg::REQ_PUSH_BACK, 0, 1);
    send_request(bdl_pkg::REQ_PUSH_FRONT, 0, 2);
    send_request(bdl_pkg::REQ_INSERT, 7'd64, 3);
    send_request(bdl_pkg::REQ_INSERT, 7'd65, 3);
    send_request(bdl_pkg::REQ_AT, 7'd63, 0);
    send_request(bdl_pkg::REQ_REMOVE, 7'd62, 0);
    send_request(bdl_pkg::REQ_INSERT, 7'd30, 9);
    send_request(bdl_pkg::REQ_SIZE, 0, 0);
    send_request(bdl_pkg::REQ_CLEAR, 0, 0);
    drain_results();
  endtask

  task automatic test_random_ops(int n);
    logic [3:0] req;
    logic [6:0] idx;
    int cnt;
    for (int i = 0; i < n; i++) begin
      cnt = shadow_list.size();
      // Favour pushes and inserts so the list grows deep; clear is rare.
      case ($urandom_range(0, 19))
        0, 1, 2: req = bdl_pkg::REQ_PUSH_BACK;
        3, 4: req = bdl_pkg::REQ_PUSH_FRONT;
        5, 6, 7: req = bdl_pkg::REQ_INSERT;
        8: req = bdl_pkg::REQ_POP_BACK;
        9: req = bdl_pkg::REQ_POP_FRONT;
        10: req = bdl_pkg::REQ_BACK;
        11: req = bdl_pkg::REQ_FRONT;
        12, 13: req = bdl_pkg::REQ_AT;
        14, 15: req = bdl_pkg::REQ_REMOVE;
        16: req = bdl_pkg::REQ_SIZE;
        17: req = ($urandom_range(0, 3) == 0) ? bdl_pkg::REQ_CLEAR : bdl_pkg::REQ_AT;
        default: req = 4'($urandom_range(0, 15));
      endcase
      if ($urandom_range(0, 9) == 0) idx = 7'($urandom);
      else idx = 7'($urandom_range(0, cnt));
      send_request(req, idx, random_value());
      if (i == n / 2) drain_results();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_basic_ops();
    test_full_list();
    test_random_ops(460);
    finish_stream();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Slowest run: ~600 requests plus stalls and gaps.
  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
